// ----- src/sequential_list_engine_defines.svh -----
// Assertion macros shared by the list engine modules.
`ifndef SEQUENTIAL_LIST_ENGINE_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define SLE_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("list engine check failed");
`define SLE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("list engine check failed");
`else
`define SLE_ASSERT_SAME(label, ante, cons)
`define SLE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- src/sle_pkg.sv -----
// Package with the constants, codes and interface types of the list engine.
`timescale 1ns / 1ps
package sle_pkg;
	localparam int CAPACITY  = 128;
	localparam int AW        = $clog2(CAPACITY);
	localparam int CW        = $clog2(CAPACITY + 1);
	localparam int POS_W     = 8;
	localparam int DATA_W    = 32;
	localparam int CMD_W     = 3;
	localparam int STAT_W    = 2;
	localparam int CNT_OUT_W = 8;
	localparam int CMPW      = ((CW > POS_W) ? CW : POS_W) + 1;

	localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_READ    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef logic [3:0] op_t;
	localparam op_t OP_NONE      = 4'd0;
	localparam op_t OP_LOAD      = 4'd1;
	localparam op_t OP_INS_START = 4'd2;
	localparam op_t OP_INS_STEP  = 4'd3;
	localparam op_t OP_INS_VAL   = 4'd4;
	localparam op_t OP_RD_POS    = 4'd5;
	localparam op_t OP_CAPTURE   = 4'd6;
	localparam op_t OP_DEL_STEP  = 4'd7;
	localparam op_t OP_DEL_END   = 4'd8;
	localparam op_t OP_CLR       = 4'd9;
	localparam op_t OP_REV_START = 4'd10;
	localparam op_t OP_REV_RD    = 4'd11;
	localparam op_t OP_REV_WLO   = 4'd12;
	localparam op_t OP_REV_WHI   = 4'd13;
	localparam op_t OP_RESULT    = 4'd14;

	typedef struct packed {
		op_t               op;
		logic [STAT_W-1:0] res_status;
	} ctrl_t;

	typedef struct packed {
		logic pos_ins_ok;
		logic pos_ok;
		logic full;
		logic ins_more;
		logic del_more;
		logic rev_more;
		logic rev_last;
	} stat_t;
endpackage

// ----- src/sle_datapath.sv -----
// Datapath of the list engine: element store, count, pointers and result registers.
`timescale 1ns / 1ps
`include "sequential_list_engine_defines.svh"
module sle_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [sle_pkg::POS_W-1:0]           position,
	input  logic signed [sle_pkg::DATA_W-1:0]   value,
	input  sle_pkg::ctrl_t                      ctrl,
	output sle_pkg::stat_t                      stat,
	output logic [sle_pkg::STAT_W-1:0]          status,
	output logic signed [sle_pkg::DATA_W-1:0]   element,
	output logic [sle_pkg::CNT_OUT_W-1:0]       count_now
);
	logic [sle_pkg::DATA_W-1:0]      store_q [sle_pkg::CAPACITY];
	logic [sle_pkg::POS_W-1:0]       pos_q;
	logic [sle_pkg::DATA_W-1:0]      val_q;
	logic [sle_pkg::CW-1:0]          count_q;
	logic [sle_pkg::CW-1:0]          k_q;
	logic [sle_pkg::CW-1:0]          hi_q;
	logic                            pend_q;
	logic [sle_pkg::AW-1:0]          pend_addr_q;
	logic [sle_pkg::DATA_W-1:0]      rd_a_q;
	logic [sle_pkg::DATA_W-1:0]      rd_b_q;
	logic [sle_pkg::DATA_W-1:0]      elem_q;
	logic [sle_pkg::STAT_W-1:0]      status_q;
	logic [sle_pkg::DATA_W-1:0]      element_q;
	logic [sle_pkg::CNT_OUT_W-1:0]   count_now_q;

	logic                            wr_en;
	logic [sle_pkg::AW-1:0]          wr_addr;
	logic [sle_pkg::DATA_W-1:0]      wr_data;
	logic                            ra_en;
	logic                            rb_en;
	logic [sle_pkg::AW-1:0]          ra_addr;
	logic [sle_pkg::AW-1:0]          rb_addr;
	logic [sle_pkg::CMPW-1:0]        pos_w;
	logic [sle_pkg::CMPW-1:0]        cnt_w;
	logic [sle_pkg::CMPW-1:0]        k_w;
	logic [sle_pkg::CMPW-1:0]        cnt_half;

	assign pos_w    = sle_pkg::CMPW'(pos_q);
	assign cnt_w    = sle_pkg::CMPW'(count_q);
	assign k_w      = sle_pkg::CMPW'(k_q);
	assign cnt_half = cnt_w >> 1;

	assign stat.pos_ins_ok = (pos_w != '0) && (pos_w <= cnt_w + 1'b1);
	assign stat.pos_ok     = (pos_w != '0) && (pos_w <= cnt_w);
	assign stat.full       = cnt_w >= sle_pkg::CMPW'(sle_pkg::CAPACITY);
	assign stat.ins_more   = k_w >= pos_w;
	assign stat.del_more   = k_w < cnt_w;
	assign stat.rev_more   = k_w < cnt_half;
	assign stat.rev_last   = (k_w + 1'b1) >= cnt_half;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		ra_en   = 1'b0;
		rb_en   = 1'b0;
		ra_addr = '0;
		rb_addr = '0;
		if (pend_q) begin
			wr_en   = 1'b1;
			wr_addr = pend_addr_q;
			wr_data = rd_a_q;
		end
		case (ctrl.op)
			sle_pkg::OP_INS_STEP: begin
				ra_en   = 1'b1;
				ra_addr = sle_pkg::AW'(k_q - 1'b1);
			end
			sle_pkg::OP_DEL_STEP: begin
				ra_en   = 1'b1;
				ra_addr = sle_pkg::AW'(k_q);
			end
			sle_pkg::OP_RD_POS: begin
				ra_en   = 1'b1;
				ra_addr = sle_pkg::AW'(pos_w - 1'b1);
			end
			sle_pkg::OP_INS_VAL: begin
				wr_en   = 1'b1;
				wr_addr = sle_pkg::AW'(pos_w - 1'b1);
				wr_data = val_q;
			end
			sle_pkg::OP_REV_RD: begin
				ra_en   = 1'b1;
				rb_en   = 1'b1;
				ra_addr = sle_pkg::AW'(k_q);
				rb_addr = sle_pkg::AW'(hi_q);
			end
			sle_pkg::OP_REV_WLO: begin
				wr_en   = 1'b1;
				wr_addr = sle_pkg::AW'(k_q);
				wr_data = rd_b_q;
			end
			sle_pkg::OP_REV_WHI: begin
				wr_en   = 1'b1;
				wr_addr = sle_pkg::AW'(hi_q);
				wr_data = rd_a_q;
				ra_en   = 1'b1;
				rb_en   = 1'b1;
				ra_addr = sle_pkg::AW'(k_q + 1'b1);
				rb_addr = sle_pkg::AW'(hi_q - 1'b1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
		if (ra_en) begin
			rd_a_q <= store_q[ra_addr];
		end
		if (rb_en) begin
			rd_b_q <= store_q[rb_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			pend_q <= (ctrl.op == sle_pkg::OP_INS_STEP) || (ctrl.op == sle_pkg::OP_DEL_STEP);
			case (ctrl.op)
				sle_pkg::OP_INS_VAL: count_q <= count_q + 1'b1;
				sle_pkg::OP_DEL_END: count_q <= count_q - 1'b1;
				sle_pkg::OP_CLR:     count_q <= '0;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			sle_pkg::OP_LOAD: begin
				pos_q  <= position;
				val_q  <= value;
				elem_q <= '0;
			end
			sle_pkg::OP_INS_START: begin
				k_q <= count_q;
			end
			sle_pkg::OP_INS_STEP: begin
				pend_addr_q <= sle_pkg::AW'(k_q);
				k_q         <= k_q - 1'b1;
			end
			sle_pkg::OP_RD_POS: begin
				k_q <= sle_pkg::CW'(pos_q);
			end
			sle_pkg::OP_CAPTURE: begin
				elem_q <= rd_a_q;
			end
			sle_pkg::OP_DEL_STEP: begin
				pend_addr_q <= sle_pkg::AW'(k_q - 1'b1);
				k_q         <= k_q + 1'b1;
			end
			sle_pkg::OP_REV_START: begin
				k_q  <= '0;
				hi_q <= count_q - 1'b1;
			end
			sle_pkg::OP_REV_WHI: begin
				k_q  <= k_q + 1'b1;
				hi_q <= hi_q - 1'b1;
			end
			sle_pkg::OP_RESULT: begin
				status_q    <= ctrl.res_status;
				element_q   <= elem_q;
				count_now_q <= sle_pkg::CNT_OUT_W'(count_q);
			end
			default: begin
			end
		endcase
	end

	assign status    = status_q;
	assign element   = element_q;
	assign count_now = count_now_q;

	`SLE_ASSERT_SAME(a_count_bound, 1'b1, cnt_w <= sle_pkg::CMPW'(sle_pkg::CAPACITY))
	`SLE_ASSERT_SAME(a_no_write_clash, pend_q, (ctrl.op != sle_pkg::OP_INS_VAL) && (ctrl.op != sle_pkg::OP_REV_WLO) && (ctrl.op != sle_pkg::OP_REV_WHI))
	`SLE_ASSERT_SAME(a_insert_room, ctrl.op == sle_pkg::OP_INS_VAL, !stat.full && stat.pos_ins_ok)
endmodule

// ----- src/sle_ctrl.sv -----
// Controller state machine of the list engine: sequences each command and the result handshake.
`timescale 1ns / 1ps
`include "sequential_list_engine_defines.svh"
module sle_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [sle_pkg::CMD_W-1:0]   command,
	output logic                        out_valid,
	input  logic                        out_ready,
	output sle_pkg::ctrl_t              ctrl,
	input  sle_pkg::stat_t              stat
);
	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_DECIDE    = 4'd1;
	localparam logic [3:0] S_INS_SHIFT = 4'd2;
	localparam logic [3:0] S_INS_VAL   = 4'd3;
	localparam logic [3:0] S_DEL_CAP   = 4'd4;
	localparam logic [3:0] S_DEL_SHIFT = 4'd5;
	localparam logic [3:0] S_RD_CAP    = 4'd6;
	localparam logic [3:0] S_REV_CHECK = 4'd7;
	localparam logic [3:0] S_REV_WLO   = 4'd8;
	localparam logic [3:0] S_REV_WHI   = 4'd9;
	localparam logic [3:0] S_DONE      = 4'd10;

	logic [3:0]                  state_q;
	logic [3:0]                  state_d;
	logic [sle_pkg::CMD_W-1:0]   cmd_q;
	logic [sle_pkg::STAT_W-1:0]  st_q;
	logic [sle_pkg::STAT_W-1:0]  st_d;
	logic                        out_valid_q;
	sle_pkg::op_t                op;

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		op      = sle_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op      = sle_pkg::OP_LOAD;
					st_d    = sle_pkg::ST_OK;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = S_DONE;
				case (cmd_q)
					sle_pkg::CMD_INSERT: begin
						if (!stat.pos_ins_ok) begin
							st_d = sle_pkg::ST_RANGE;
						end else if (stat.full) begin
							st_d = sle_pkg::ST_FULL;
						end else begin
							op      = sle_pkg::OP_INS_START;
							state_d = S_INS_SHIFT;
						end
					end
					sle_pkg::CMD_DELETE: begin
						if (!stat.pos_ok) begin
							st_d = sle_pkg::ST_RANGE;
						end else begin
							op      = sle_pkg::OP_RD_POS;
							state_d = S_DEL_CAP;
						end
					end
					sle_pkg::CMD_READ: begin
						if (!stat.pos_ok) begin
							st_d = sle_pkg::ST_RANGE;
						end else begin
							op      = sle_pkg::OP_RD_POS;
							state_d = S_RD_CAP;
						end
					end
					sle_pkg::CMD_CLEAR: begin
						op = sle_pkg::OP_CLR;
					end
					sle_pkg::CMD_REVERSE: begin
						op      = sle_pkg::OP_REV_START;
						state_d = S_REV_CHECK;
					end
					default: begin
					end
				endcase
			end
			S_INS_SHIFT: begin
				if (stat.ins_more) begin
					op = sle_pkg::OP_INS_STEP;
				end else begin
					state_d = S_INS_VAL;
				end
			end
			S_INS_VAL: begin
				op      = sle_pkg::OP_INS_VAL;
				state_d = S_DONE;
			end
			S_DEL_CAP: begin
				op      = sle_pkg::OP_CAPTURE;
				state_d = S_DEL_SHIFT;
			end
			S_DEL_SHIFT: begin
				if (stat.del_more) begin
					op = sle_pkg::OP_DEL_STEP;
				end else begin
					op      = sle_pkg::OP_DEL_END;
					state_d = S_DONE;
				end
			end
			S_RD_CAP: begin
				op      = sle_pkg::OP_CAPTURE;
				state_d = S_DONE;
			end
			S_REV_CHECK: begin
				if (stat.rev_more) begin
					op      = sle_pkg::OP_REV_RD;
					state_d = S_REV_WLO;
				end else begin
					state_d = S_DONE;
				end
			end
			S_REV_WLO: begin
				op      = sle_pkg::OP_REV_WLO;
				state_d = S_REV_WHI;
			end
			S_REV_WHI: begin
				op      = sle_pkg::OP_REV_WHI;
				state_d = stat.rev_last ? S_DONE : S_REV_WLO;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					op      = sle_pkg::OP_RESULT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op == sle_pkg::OP_RESULT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		st_q <= st_d;
		if (op == sle_pkg::OP_LOAD) begin
			cmd_q <= command;
		end
	end

	assign in_ready        = (state_q == S_IDLE);
	assign out_valid       = out_valid_q;
	assign ctrl.op         = op;
	assign ctrl.res_status = st_q;

	`SLE_ASSERT_SAME(a_result_slot_free, op == sle_pkg::OP_RESULT, !out_valid_q || out_ready)
	`SLE_ASSERT_NEXT(a_accept_decides, in_valid && in_ready, state_q == S_DECIDE)
	`SLE_ASSERT_NEXT(a_result_shown, op == sle_pkg::OP_RESULT, out_valid_q && (state_q == S_IDLE))
endmodule

// ----- src/sequential_list_engine.sv -----
// Top level of the list engine: controller and datapath.
// The block keeps an ordered list of up to 128 signed 32-bit elements with a count.
// Input channel (in_valid/in_ready) carries command, position and value; the output
// channel (out_valid/out_ready) returns status, element and count_now, one item per
// input item and in the same order.
// The engine works on one item at a time. in_ready is high while the controller idles.
// From acceptance, each command passes the decide state; clear, unknown and failing
// commands then go to the result, read first captures its element, insert moves each
// element from the position on up and then writes the value, delete captures the
// element and moves the elements behind it down; reverse swaps pairs from both ends.
// The controller returns to idle and raises in_ready in the same cycle that the result
// is shown. The element store has a single write port, so each move or half swap is
// one write.
// A finished result waits in the output register while the next item is accepted and
// worked on; when the receiver stalls, the engine holds its second result until the
// register is taken.
// Reset clears the count, so the list is empty; the store content is not cleared and
// no entry is read before it is written.
`timescale 1ns / 1ps
module sequential_list_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [sle_pkg::CMD_W-1:0]           command,
	input  logic [sle_pkg::POS_W-1:0]           position,
	input  logic signed [sle_pkg::DATA_W-1:0]   value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sle_pkg::STAT_W-1:0]          status,
	output logic signed [sle_pkg::DATA_W-1:0]   element,
	output logic [sle_pkg::CNT_OUT_W-1:0]       count_now
);
	sle_pkg::ctrl_t ctrl;
	sle_pkg::stat_t stat;

	sle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctrl      (ctrl),
		.stat      (stat)
	);

	sle_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.position  (position),
		.value     (value),
		.ctrl      (ctrl),
		.stat      (stat),
		.status    (status),
		.element   (element),
		.count_now (count_now)
	);
endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the sequential list engine with random handshakes.
`timescale 1ns / 1ps
module tb_top;
	typedef struct packed {
		logic [sle_pkg::CMD_W-1:0]          command;
		logic [sle_pkg::POS_W-1:0]          position;
		logic signed [sle_pkg::DATA_W-1:0]  value;
		logic                               drain_first;
	} list_command_t;

	typedef struct packed {
		logic [sle_pkg::STAT_W-1:0]         status;
		logic signed [sle_pkg::DATA_W-1:0]  element;
		logic [sle_pkg::CNT_OUT_W-1:0]      count_now;
	} list_result_t;

	localparam logic [sle_pkg::CMD_W-1:0] CMD_TOP_CODE = {sle_pkg::CMD_W{1'b1}};
	localparam int RANDOM_ITEMS = 750;
	localparam int DRAIN_AT_ITEM = 620;
	localparam int STEADY_FROM = 200;
	localparam int STEADY_TO = 330;
	localparam int HOLD_AT_RESULT = 450;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 150;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [sle_pkg::CMD_W-1:0] command = '0;
	logic [sle_pkg::POS_W-1:0] position = '0;
	logic signed [sle_pkg::DATA_W-1:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [sle_pkg::STAT_W-1:0] status;
	logic signed [sle_pkg::DATA_W-1:0] element;
	logic [sle_pkg::CNT_OUT_W-1:0] count_now;

	list_command_t pending_cmds[$];
	list_result_t awaited_results[$];
	logic signed [sle_pkg::DATA_W-1:0] model_store[sle_pkg::CAPACITY];
	int model_len = 0;
	int planned_len = 0;
	int planned_items = 0;
	int accepted_count = 0;
	int results_taken = 0;
	int mismatches = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit in_fired = 1'b0;

	sequential_list_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.element(element),
		.count_now(count_now)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		$display("Mismatch on %s at result %0d: got %0h, expected %0h", what,
			results_taken, got, want);
	endtask

	task automatic apply_list_command(input logic [sle_pkg::CMD_W-1:0] cmd,
			input logic [sle_pkg::POS_W-1:0] pos,
			input logic signed [sle_pkg::DATA_W-1:0] val);
		list_result_t r;
		int p;
		int k;
		logic signed [sle_pkg::DATA_W-1:0] tmp;
		p = int'(pos);
		r.status = sle_pkg::ST_OK;
		r.element = '0;
		case (cmd)
			sle_pkg::CMD_INSERT: begin
				if (p < 1 || p > model_len + 1) begin
					r.status = sle_pkg::ST_RANGE;
				end else if (model_len >= sle_pkg::CAPACITY) begin
					r.status = sle_pkg::ST_FULL;
				end else begin
					for (k = model_len; k >= p; k--)
						model_store[k] = model_store[k - 1];
					model_store[p - 1] = val;
					model_len++;
				end
			end
			sle_pkg::CMD_DELETE: begin
				if (p < 1 || p > model_len) begin
					r.status = sle_pkg::ST_RANGE;
				end else begin
					r.element = model_store[p - 1];
					for (k = p; k < model_len; k++)
						model_store[k - 1] = model_store[k];
					model_len--;
				end
			end
			sle_pkg::CMD_READ: begin
				if (p < 1 || p > model_len) begin
					r.status = sle_pkg::ST_RANGE;
				end else begin
					r.element = model_store[p - 1];
				end
			end
			sle_pkg::CMD_CLEAR: begin
				model_len = 0;
			end
			sle_pkg::CMD_REVERSE: begin
				for (k = 0; k < model_len / 2; k++) begin
					tmp = model_store[k];
					model_store[k] = model_store[model_len - 1 - k];
					model_store[model_len - 1 - k] = tmp;
				end
			end
			default: begin
			end
		endcase
		r.count_now = model_len[sle_pkg::CNT_OUT_W-1:0];
		awaited_results.push_back(r);
	endtask

	task automatic plan_command(input logic [sle_pkg::CMD_W-1:0] cmd, input int pos,
			input logic [sle_pkg::DATA_W-1:0] val);
		list_command_t c;
		c.command = cmd;
		c.position = pos[sle_pkg::POS_W-1:0];
		c.value = val;
		c.drain_first = (planned_items == DRAIN_AT_ITEM);
		pending_cmds.push_back(c);
		planned_items++;
		if (cmd == sle_pkg::CMD_INSERT && pos >= 1 && pos <= planned_len + 1
				&& planned_len < sle_pkg::CAPACITY)
			planned_len++;
		else if (cmd == sle_pkg::CMD_DELETE && pos >= 1 && pos <= planned_len)
			planned_len--;
		else if (cmd == sle_pkg::CMD_CLEAR)
			planned_len = 0;
	endtask

	function automatic logic [sle_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: pick_value = 32'h8000_0000;
			1: pick_value = 32'h7fff_ffff;
			2: pick_value = '0;
			3: pick_value = '1;
			default: pick_value = $urandom;
		endcase
	endfunction

	function automatic int pick_held_pos();
		pick_held_pos = (planned_len == 0) ? 1 : int'($urandom_range(1, planned_len));
	endfunction

	function automatic logic [sle_pkg::CMD_W-1:0] CMD_CMD_PICK();
		CMD_CMD_PICK = sle_pkg::CMD_W'($urandom_range(int'(sle_pkg::CMD_REVERSE) + 1,
			int'(CMD_TOP_CODE)));
	endfunction

	task automatic plan_fill_and_probe();
		while (planned_len < sle_pkg::CAPACITY)
			plan_command(sle_pkg::CMD_INSERT, int'($urandom_range(1, planned_len + 1)),
				pick_value());
		plan_command(sle_pkg::CMD_INSERT, sle_pkg::CAPACITY, pick_value());
		plan_command(sle_pkg::CMD_INSERT, sle_pkg::CAPACITY + 1, pick_value());
		plan_command(sle_pkg::CMD_INSERT, sle_pkg::CAPACITY + 2, pick_value());
		plan_command(sle_pkg::CMD_INSERT, 0, pick_value());
		plan_command(sle_pkg::CMD_REVERSE, $urandom_range(0, 255), $urandom);
		plan_command(sle_pkg::CMD_READ, sle_pkg::CAPACITY, $urandom);
		plan_command(sle_pkg::CMD_READ, 1, $urandom);
		plan_command(sle_pkg::CMD_READ, sle_pkg::CAPACITY + 1, $urandom);
		plan_command(sle_pkg::CMD_DELETE, sle_pkg::CAPACITY, $urandom);
		plan_command(sle_pkg::CMD_DELETE, 1, $urandom);
		plan_command(sle_pkg::CMD_REVERSE, $urandom_range(0, 255), $urandom);
	endtask

	task automatic plan_regular_run(input int n);
		int i;
		int r;
		for (i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 40)
				plan_command(sle_pkg::CMD_INSERT, int'($urandom_range(1, planned_len + 1)),
					pick_value());
			else if (r < 60)
				plan_command(sle_pkg::CMD_DELETE, pick_held_pos(), $urandom);
			else if (r < 80)
				plan_command(sle_pkg::CMD_READ, pick_held_pos(), $urandom);
			else if (r < 88)
				plan_command(sle_pkg::CMD_REVERSE, $urandom_range(0, 255), $urandom);
			else if (r < 90)
				plan_command(sle_pkg::CMD_CLEAR, $urandom_range(0, 255), $urandom);
			else if (r < 93)
				plan_command(sle_pkg::CMD_READ, planned_len + 1, $urandom);
			else if (r < 96)
				plan_command(sle_pkg::CMD_DELETE, planned_len + 1, $urandom);
			else
				plan_command(CMD_CMD_PICK(), $urandom_range(0, 255), $urandom);
		end
	endtask

	task automatic plan_noise(input int n);
		int i;
		for (i = 0; i < n; i++)
			plan_command(sle_pkg::CMD_W'($urandom_range(0, int'(CMD_TOP_CODE))),
				$urandom_range(0, 255), $urandom);
	endtask

	task automatic plan_directed();
		int c;
		plan_command(sle_pkg::CMD_READ, 1, 0);
		plan_command(sle_pkg::CMD_DELETE, 1, 0);
		plan_command(sle_pkg::CMD_REVERSE, 0, 0);
		plan_command(sle_pkg::CMD_INSERT, 0, 32'h1234_5678);
		plan_command(sle_pkg::CMD_INSERT, 2, 32'h1234_5678);
		plan_command(sle_pkg::CMD_INSERT, 1, 32'h8000_0000);
		plan_command(sle_pkg::CMD_REVERSE, 255, 32'hffff_ffff);
		plan_command(sle_pkg::CMD_INSERT, 2, 32'h7fff_ffff);
		plan_command(sle_pkg::CMD_INSERT, 1, 32'hffff_ffff);
		plan_command(sle_pkg::CMD_INSERT, 2, 32'h0000_0000);
		plan_command(sle_pkg::CMD_READ, 4, 0);
		plan_command(sle_pkg::CMD_READ, 5, 0);
		plan_command(sle_pkg::CMD_READ, 0, 0);
		plan_command(sle_pkg::CMD_REVERSE, 0, 0);
		plan_command(sle_pkg::CMD_INSERT, 3, 32'h5555_5555);
		plan_command(sle_pkg::CMD_REVERSE, 0, 0);
		plan_command(sle_pkg::CMD_DELETE, 5, 0);
		plan_command(sle_pkg::CMD_DELETE, 1, 0);
		plan_command(sle_pkg::CMD_DELETE, 0, 0);
		plan_command(sle_pkg::CMD_DELETE, 255, 32'haaaa_aaaa);
		for (c = int'(sle_pkg::CMD_REVERSE) + 1; c <= int'(CMD_TOP_CODE); c++)
			plan_command(sle_pkg::CMD_W'(c), 255, 32'hffff_ffff);
		plan_command(sle_pkg::CMD_READ, 255, 0);
		plan_command(sle_pkg::CMD_CLEAR, 255, 32'hffff_ffff);
		plan_command(sle_pkg::CMD_READ, 1, 0);
	endtask

	always @(negedge clk) begin : drive_proc
		list_command_t nxt;
		bit quiet;
		if (arst_n && (!in_valid || in_fired)) begin
			quiet = (accepted_count < STEADY_FROM || accepted_count >= STEADY_TO)
				&& ($urandom_range(0, 99) < 34);
			if (pending_cmds.size() == 0 || quiet) begin
				in_valid <= 1'b0;
			end else if (pending_cmds[0].drain_first && awaited_results.size() != 0) begin
				in_valid <= 1'b0;
			end else begin
				nxt = pending_cmds.pop_front();
				in_valid <= 1'b1;
				command <= nxt.command;
				position <= nxt.position;
				value <= nxt.value;
			end
		end
	end

	always @(negedge clk) begin : accept_proc
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!hold_done && results_taken >= HOLD_AT_RESULT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (results_taken >= STEADY_FROM && results_taken < STEADY_TO) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= 34);
		end
	end

	always @(posedge clk) begin : observe_proc
		list_result_t want;
		in_fired = arst_n && in_valid && in_ready;
		if (in_fired) begin
			accepted_count++;
			apply_list_command(command, position, value);
		end
		if (arst_n && out_valid && out_ready) begin
			results_taken++;
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected item", 64'({status, element, count_now}), '0);
			end else begin
				want = awaited_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", 64'(status), 64'(want.status));
				if (element !== want.element)
					report_mismatch("element", 64'(element), 64'(want.element));
				if (count_now !== want.count_now)
					report_mismatch("count_now", 64'(count_now), 64'(want.count_now));
			end
		end
	end

	initial begin : stimulus_proc
		int r;
		arst_n = 1'b0;
		plan_directed();
		plan_fill_and_probe();
		while (planned_items < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 6 && planned_len < sle_pkg::CAPACITY
					&& planned_items + sle_pkg::CAPACITY + 11 < RANDOM_ITEMS)
				plan_fill_and_probe();
			else if (r < 90)
				plan_regular_run(8);
			else
				plan_noise(4);
		end
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		while (pending_cmds.size() != 0 || in_valid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin : watchdog_proc
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
